// File: src/osa_edit_distance_column_engine_core_defines.svh
// Assertion macros for the edit distance column engine.
`ifndef OSA_EDIT_DISTANCE_COLUMN_ENGINE_CORE_DEFINES_SVH
`define OSA_EDIT_DISTANCE_COLUMN_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, checked after reset.
`define OSA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked after reset.
`define OSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: src/osa_pkg.sv
// Shared constants and helpers for the edit distance column engine.
`timescale 1ns / 1ps
`default_nettype none

package osa_pkg;

    localparam int CHW  = 16;
    localparam int OUTW = 6;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_PUSH   = 2'd2;
    localparam logic [1:0] OP_POP    = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_CFULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_QUERY  = 2'd3;

    // Clamp a length or distance to the 6-bit output range.
    function automatic logic [OUTW-1:0] f_sat6(input logic [7:0] v);
        return (v > 8'd63) ? 6'd63 : v[OUTW-1:0];
    endfunction

endpackage

`default_nettype wire

// File: src/osa_edit_distance_column_engine_core.sv
// Top level: OSA edit distance engine with a column-per-push distance table.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_stall     | i_op, i_ch
//  out     | output    | o_out_valid / i_out_stall   | o_distance, o_cand_len,
//          |           |                             | o_query_len, o_status
//
// A push that computes a column steps through S_FILL at one table row per cycle,
// limited by the single write port of the distance table RAM, then S_DONE. Every other
// beat, a full push and a push onto an empty query included, passes S_LOOK and S_DONE.
// One item is in work at a time; the next beat is taken while a result waits.
// Reset clears counts and control only; table edge cells come from logic, so no
// clearing pass runs. A stalled result holds in the output register.
`timescale 1ns / 1ps
`default_nettype none

module osa_edit_distance_column_engine_core #(
    parameter int MAX_CAND_LEN  = 32,
    parameter int MAX_QUERY_LEN = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_op,
    input  logic [osa_pkg::CHW-1:0]  i_ch,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [osa_pkg::OUTW-1:0] o_distance,
    output logic [osa_pkg::OUTW-1:0] o_cand_len,
    output logic [osa_pkg::OUTW-1:0] o_query_len,
    output logic [1:0]               o_status
);
    import osa_pkg::*;

    `include "osa_edit_distance_column_engine_core_defines.svh"

    localparam int COLS  = MAX_CAND_LEN + 1;
    localparam int ROWS  = MAX_QUERY_LEN + 1;
    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int QW    = $clog2(MAX_QUERY_LEN + 1);
    localparam int CW    = $clog2(MAX_CAND_LEN + 1);
    localparam int QAW   = $clog2(MAX_QUERY_LEN);
    localparam int CAW   = $clog2(MAX_CAND_LEN);
    localparam int MAXL  = (MAX_CAND_LEN > MAX_QUERY_LEN) ? MAX_CAND_LEN : MAX_QUERY_LEN;
    localparam int DW    = $clog2(MAXL + 1);
    localparam int EW    = DW + 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FILL = 4'b0010,
        S_LOOK = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    function automatic logic [AW-1:0] f_addr(input logic [QW-1:0] row,
                                             input logic [CW-1:0] col);
        return AW'(int'(row) * COLS + int'(col));
    endfunction

    t_state            r_state, n_state;
    logic [QW-1:0]     r_qcnt, n_qcnt;
    logic [CW-1:0]     r_ccnt, n_ccnt;
    logic [1:0]        r_stat, n_stat;
    logic [CW-1:0]     r_j, n_j;
    logic [CHW-1:0]    r_cc, n_cc;
    logic [QW-1:0]     r_row, n_row;
    logic [DW-1:0]     r_up, n_up;
    logic [DW-1:0]     r_diag, n_diag;
    logic [CHW-1:0]    r_qprev, n_qprev;
    logic [DW-1:0]     r_dist, n_dist;
    logic              r_ov;
    logic [OUTW-1:0]   r_o_dist, r_o_clen, r_o_qlen;
    logic [1:0]        r_o_stat;

    logic              w_acc, w_load;
    logic              w_push_ok, w_app_ok, w_pop_ok;
    logic [CW-1:0]     w_cm1;

    logic              d_we, d_re;
    logic [AW-1:0]     d_wa, d_ra_a, d_ra_b;
    logic [DW-1:0]     d_wd, d_rd_a, d_rd_b;
    logic              q_we, q_re;
    logic [QAW-1:0]    q_ra;
    logic [CHW-1:0]    q_rd;
    logic              c_we, c_re;
    logic [CHW-1:0]    c_rd;

    logic [DW-1:0]     w_left, w_tcell, w_v;
    logic              w_tr, w_mis;
    logic [EW-1:0]     w_m1, w_m2, w_m3;

    assign w_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_cm1      = r_ccnt - CW'(1);

    assign w_push_ok = (i_op == OP_PUSH) && (r_ccnt < CW'(MAX_CAND_LEN));
    assign w_app_ok  = (i_op == OP_APPEND) && (r_ccnt == '0)
                    && (r_qcnt < QW'(MAX_QUERY_LEN));
    assign w_pop_ok  = (i_op == OP_POP) && (r_ccnt != '0);

    osa_char_ram #(.DEPTH(MAX_QUERY_LEN), .AW(QAW)) u_query_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (r_qcnt[QAW-1:0]),
        .i_wdata (i_ch),
        .i_re    (q_re),
        .i_raddr (q_ra),
        .o_rdata (q_rd)
    );

    osa_char_ram #(.DEPTH(MAX_CAND_LEN), .AW(CAW)) u_cand_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (r_ccnt[CAW-1:0]),
        .i_wdata (i_ch),
        .i_re    (c_re),
        .i_raddr (w_cm1[CAW-1:0]),
        .o_rdata (c_rd)
    );

    osa_dist_ram #(.DEPTH(DEPTH), .AW(AW), .DW(DW)) u_dist_ram (
        .i_clk     (i_clk),
        .i_we      (d_we),
        .i_waddr   (d_wa),
        .i_wdata   (d_wd),
        .i_re      (d_re),
        .i_raddr_a (d_ra_a),
        .i_raddr_b (d_ra_b),
        .o_rdata_a (d_rd_a),
        .o_rdata_b (d_rd_b)
    );

    // Cell update for row r_row of column r_j; edge cells come from their index.
    always_comb begin
        w_left  = (r_j == CW'(1)) ? DW'(r_row) : d_rd_a;
        w_tcell = (r_row == QW'(2)) ? DW'(r_j - CW'(2)) :
                  (r_j == CW'(2))   ? DW'(r_row - QW'(2)) : d_rd_b;
        w_mis   = (q_rd != r_cc);
        w_tr    = (r_row > QW'(1)) && (r_j > CW'(1)) && (q_rd == c_rd) && (r_qprev == r_cc);
        w_m1    = EW'(r_up) + EW'(1);
        if (EW'(w_left) + EW'(1) < w_m1) begin
            w_m1 = EW'(w_left) + EW'(1);
        end
        w_m2 = EW'(r_diag) + EW'(w_mis);
        if (w_m2 < w_m1) begin
            w_m1 = w_m2;
        end
        w_m3 = EW'(w_tcell) + EW'(1);
        if (w_tr && (w_m3 < w_m1)) begin
            w_m1 = w_m3;
        end
        w_v = w_m1[DW-1:0];
    end

    always_comb begin
        n_state = r_state;
        n_qcnt  = r_qcnt;
        n_ccnt  = r_ccnt;
        n_stat  = r_stat;
        n_j     = r_j;
        n_cc    = r_cc;
        n_row   = r_row;
        n_up    = r_up;
        n_diag  = r_diag;
        n_qprev = r_qprev;
        n_dist  = r_dist;
        w_load  = 1'b0;
        d_we    = 1'b0;
        d_wa    = '0;
        d_wd    = '0;
        d_re    = 1'b0;
        d_ra_a  = '0;
        d_ra_b  = '0;
        q_we    = 1'b0;
        q_re    = 1'b0;
        q_ra    = '0;
        c_we    = 1'b0;
        c_re    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_stat  = ST_OK;
                    n_state = S_LOOK;
                    d_re    = 1'b1;
                    unique case (i_op)
                        OP_CLEAR: begin
                            n_qcnt = '0;
                            n_ccnt = '0;
                        end
                        OP_APPEND: begin
                            if (w_app_ok) begin
                                q_we   = 1'b1;
                                n_qcnt = r_qcnt + QW'(1);
                            end else begin
                                n_stat = ST_QUERY;
                            end
                        end
                        OP_PUSH: begin
                            if (w_push_ok) begin
                                c_we   = 1'b1;
                                c_re   = 1'b1;
                                n_ccnt = r_ccnt + CW'(1);
                                n_j    = r_ccnt + CW'(1);
                                n_cc   = i_ch;
                                if (r_qcnt != '0) begin
                                    // start at row 1: up is cell(0,j), diag is cell(0,j-1)
                                    n_state = S_FILL;
                                    q_re    = 1'b1;
                                    n_row   = QW'(1);
                                    n_up    = DW'(r_ccnt + CW'(1));
                                    n_diag  = DW'(r_ccnt);
                                end
                            end else begin
                                n_stat = ST_CFULL;
                            end
                        end
                        OP_POP: begin
                            if (w_pop_ok) begin
                                n_ccnt = r_ccnt - CW'(1);
                            end else begin
                                n_stat = ST_EMPTY;
                            end
                        end
                    endcase
                    if (n_state == S_FILL) begin
                        d_ra_a = f_addr(QW'(1), r_ccnt);
                    end else begin
                        d_ra_a = f_addr(n_qcnt, n_ccnt);
                    end
                end
            end
            S_FILL: begin
                d_we    = 1'b1;
                d_wa    = f_addr(r_row, r_j);
                d_wd    = w_v;
                n_up    = w_v;
                n_diag  = w_left;
                n_qprev = q_rd;
                if (r_row == r_qcnt) begin
                    n_dist  = w_v;
                    n_state = S_DONE;
                end else begin
                    // fetch the next row; it reads only columns j-1 and j-2
                    n_row  = r_row + QW'(1);
                    d_re   = 1'b1;
                    d_ra_a = f_addr(r_row + QW'(1), r_j - CW'(1));
                    d_ra_b = f_addr(r_row - QW'(1), (r_j >= CW'(2)) ? r_j - CW'(2) : '0);
                    q_re   = 1'b1;
                    q_ra   = r_row[QAW-1:0];
                end
            end
            S_LOOK: begin
                if (r_ccnt == '0) begin
                    n_dist = DW'(r_qcnt);
                end else if (r_qcnt == '0) begin
                    n_dist = DW'(r_ccnt);
                end else begin
                    n_dist = d_rd_a;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || !i_out_stall) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_qcnt  <= '0;
            r_ccnt  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_qcnt  <= n_qcnt;
            r_ccnt  <= n_ccnt;
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_stat  <= n_stat;
        r_j     <= n_j;
        r_cc    <= n_cc;
        r_row   <= n_row;
        r_up    <= n_up;
        r_diag  <= n_diag;
        r_qprev <= n_qprev;
        r_dist  <= n_dist;
        if (w_load) begin
            r_o_dist <= f_sat6(8'(r_dist));
            r_o_clen <= f_sat6(8'(r_ccnt));
            r_o_qlen <= f_sat6(8'(r_qcnt));
            r_o_stat <= r_stat;
        end
    end

    assign o_out_valid = r_ov;
    assign o_distance  = r_o_dist;
    assign o_cand_len  = r_o_clen;
    assign o_query_len = r_o_qlen;
    assign o_status    = r_o_stat;

    `OSA_ASSERT_NOW(a_no_rw_clash, d_we, (d_wa != d_ra_a) && (d_wa != d_ra_b), "table rw clash")
    `OSA_ASSERT_NEXT(a_one_item, w_acc, o_in_stall, "new beat taken while an item is in work")
    `OSA_ASSERT_NOW(a_fill_row, r_state == S_FILL, (r_row != '0) && (r_row <= r_qcnt), "bad row")
    `OSA_ASSERT_NEXT(a_qfrozen, r_ccnt != '0, $stable(r_qcnt) || (r_qcnt == '0), "qcnt moved")

endmodule

`default_nettype wire

// File: src/osa_char_ram.sv
// Character store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module osa_char_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [AW-1:0]           i_waddr,
    input  logic [osa_pkg::CHW-1:0] i_wdata,
    input  logic                    i_re,
    input  logic [AW-1:0]           i_raddr,
    output logic [osa_pkg::CHW-1:0] o_rdata
);
    logic [osa_pkg::CHW-1:0] mem [DEPTH];
    logic [osa_pkg::CHW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: src/osa_dist_ram.sv
// Distance table: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module osa_dist_ram #(
    parameter int DEPTH = 1089,
    parameter int AW    = 11,
    parameter int DW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_a,
    output logic [DW-1:0] o_rdata_b
);
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata_a;
    logic [DW-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= mem[i_raddr_a];
            r_rdata_b <= mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire
